FILE: hw/rtl/ifdsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ifdsa_pkg;

  localparam int XLEN = 64;
  localparam int HALF = XLEN / 2;
  localparam int SHW  = $clog2(XLEN);

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_FDIV = 4'd3,
    OP_FMOD = 4'd4,
    OP_NEG  = 4'd5,
    OP_AND  = 4'd6,
    OP_OR   = 4'd7,
    OP_XOR  = 4'd8,
    OP_NOT  = 4'd9,
    OP_SHL  = 4'd10,
    OP_SHR  = 4'd11,
    OP_EQ   = 4'd12,
    OP_LT   = 4'd13,
    OP_LE   = 4'd14
  } op_t;

  // divider working set: partial remainder, dividend/quotient, divisor
  typedef struct packed {
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] dvs;
  } div_t;

  // fields that ride along with each item
  typedef struct packed {
    logic [3:0]      op;
    logic [XLEN-1:0] res;
    logic            dz;
    logic            na;
    logic            nb;
  } carry_t;

endpackage
`default_nettype wire

FILE: hw/rtl/int64_floor_div_shift_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline from input transfer to result valid: operand stage, multiply-sum
// stage, 64 divider cells of one quotient bit each, output register.
// Throughput: one item per cycle; the whole pipeline holds only while a
// result waits at the output.
// Reset clears all valid flags; data registers are not reset.
module int64_floor_div_shift_alu (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         operation,
  input  wire logic signed [63:0] lhs,
  input  wire logic signed [63:0] rhs,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [63:0]      result,
  output logic                    divide_by_zero
);

  localparam int W = ifdsa_pkg::XLEN;
  localparam int H = ifdsa_pkg::HALF;
  localparam int S = ifdsa_pkg::SHW;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  function automatic logic [W-1:0] shift_signed(input logic [W-1:0] v,
                                                input logic [W-1:0] cnt);
    logic [W-1:0] mag;
    begin
      mag = cnt[W-1] ? (~cnt + 1'b1) : cnt;
      if (mag[W-1:S] != '0) begin
        shift_signed = '0;
      end else if (cnt[W-1]) begin
        shift_signed = v >> mag[S-1:0];
      end else begin
        shift_signed = v << mag[S-1:0];
      end
    end
  endfunction

  // operand stage
  logic [W-1:0]      a, b, ma, mb;
  ifdsa_pkg::carry_t c0_next;
  always_comb begin
    a  = lhs;
    b  = rhs;
    ma = a[W-1] ? (~a + 1'b1) : a;
    mb = b[W-1] ? (~b + 1'b1) : b;
    c0_next.op  = operation;
    c0_next.na  = a[W-1];
    c0_next.nb  = b[W-1];
    c0_next.dz  = 1'b0;
    c0_next.res = '0;
    case (operation)
      ifdsa_pkg::OP_ADD:  c0_next.res = a + b;
      ifdsa_pkg::OP_SUB:  c0_next.res = a - b;
      ifdsa_pkg::OP_FDIV: c0_next.dz  = (b == '0);
      ifdsa_pkg::OP_FMOD: c0_next.dz  = (b == '0);
      ifdsa_pkg::OP_NEG:  c0_next.res = ~a + 1'b1;
      ifdsa_pkg::OP_AND:  c0_next.res = a & b;
      ifdsa_pkg::OP_OR:   c0_next.res = a | b;
      ifdsa_pkg::OP_XOR:  c0_next.res = a ^ b;
      ifdsa_pkg::OP_NOT:  c0_next.res = ~a;
      ifdsa_pkg::OP_SHL:  c0_next.res = shift_signed(a, b);
      ifdsa_pkg::OP_SHR:  c0_next.res = shift_signed(a, ~b + 1'b1);
      ifdsa_pkg::OP_EQ:   c0_next.res = {{(W-1){1'b0}}, (a == b)};
      ifdsa_pkg::OP_LT:   c0_next.res = {{(W-1){1'b0}}, (lhs < rhs)};
      ifdsa_pkg::OP_LE:   c0_next.res = {{(W-1){1'b0}}, (lhs <= rhs)};
      default:            c0_next.res = '0;
    endcase
  end

  logic              s0_valid, s1_valid;
  ifdsa_pkg::carry_t s0_carry, s1_carry, s1_carry_next;
  ifdsa_pkg::div_t   s0_div, s1_div;
  logic [W-1:0]      p0;
  logic [H-1:0]      p1, p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
      s1_valid <= s0_valid;
    end
  end

  // low 64 bits of the product from three 32x32 partial products
  always_comb begin
    s1_carry_next = s0_carry;
    if (s0_carry.op == ifdsa_pkg::OP_MUL) begin
      s1_carry_next.res = p0 + {p1 + p2, {H{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_carry   <= c0_next;
      s0_div.rem <= '0;
      s0_div.quo <= ma;
      s0_div.dvs <= mb;
      p0 <= a[H-1:0] * b[H-1:0];
      p1 <= H'(a[H-1:0] * b[W-1:H]);
      p2 <= H'(a[W-1:H] * b[H-1:0]);
      s1_carry <= s1_carry_next;
      s1_div   <= s0_div;
    end
  end

  // divider chain
  logic              cv [0:W];
  ifdsa_pkg::div_t   cd [0:W];
  ifdsa_pkg::carry_t cc [0:W];

  assign cv[0] = s1_valid;
  assign cd[0] = s1_div;
  assign cc[0] = s1_carry;

  for (genvar i = 0; i < W; i++) begin : g_cell
    ifdsa_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .valid_i(cv[i]),
      .div_i  (cd[i]),
      .carry_i(cc[i]),
      .valid_o(cv[i+1]),
      .div_o  (cd[i+1]),
      .carry_o(cc[i+1])
    );
  end

  // floor correction of the unsigned quotient and remainder
  logic [W-1:0] q, r, fq, trem, bval, fmod, res_next;
  logic         adj;
  always_comb begin
    q    = cd[W].quo;
    r    = cd[W].rem;
    adj  = (cc[W].na != cc[W].nb) && (r != '0);
    fq   = (cc[W].na != cc[W].nb) ? ~(q + W'(adj)) + 1'b1 : q;
    trem = cc[W].na ? ~r + 1'b1 : r;
    bval = cc[W].nb ? ~cd[W].dvs + 1'b1 : cd[W].dvs;
    fmod = adj ? trem + bval : trem;
    res_next = cc[W].res;
    if (!cc[W].dz) begin
      if (cc[W].op == ifdsa_pkg::OP_FDIV) res_next = fq;
      if (cc[W].op == ifdsa_pkg::OP_FMOD) res_next = fmod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result         <= res_next;
      divide_by_zero <= cc[W].dz;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ifdsa_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ifdsa_div_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              valid_i,
  input  wire ifdsa_pkg::div_t   div_i,
  input  wire ifdsa_pkg::carry_t carry_i,
  output logic                   valid_o,
  output ifdsa_pkg::div_t        div_o,
  output ifdsa_pkg::carry_t      carry_o
);

  logic [ifdsa_pkg::XLEN:0] shifted;
  logic [ifdsa_pkg::XLEN:0] trial;
  ifdsa_pkg::div_t          div_next;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {div_i.rem, div_i.quo[ifdsa_pkg::XLEN-1]};
    trial   = shifted - {1'b0, div_i.dvs};
    div_next.dvs = div_i.dvs;
    if (!trial[ifdsa_pkg::XLEN]) begin
      div_next.rem = trial[ifdsa_pkg::XLEN-1:0];
      div_next.quo = {div_i.quo[ifdsa_pkg::XLEN-2:0], 1'b1};
    end else begin
      div_next.rem = shifted[ifdsa_pkg::XLEN-1:0];
      div_next.quo = {div_i.quo[ifdsa_pkg::XLEN-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_o   <= div_next;
      carry_o <= carry_i;
    end
  end

endmodule
`default_nettype wire

FILE: tb/int64_floor_div_shift_alu_test.sv
`timescale 1ns / 1ps
module int64_floor_div_shift_alu_test;

  localparam int LATENCY = 67;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] operation = '0;
  logic signed [63:0] lhs = '0;
  logic signed [63:0] rhs = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] result;
  logic divide_by_zero;

  typedef struct {
    logic [63:0] res;
    logic        dz;
  } alu_out_t;

  alu_out_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_receiver = 1'b0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  int64_floor_div_shift_alu u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .lhs(lhs), .rhs(rhs), .out_valid(out_valid),
    .out_ready(out_ready), .result(result), .divide_by_zero(divide_by_zero)
  );

  function automatic logic [63:0] shift_by(logic [63:0] v, logic [63:0] cnt);
    logic [63:0] mag;
    if (cnt[63]) begin
      mag = -cnt;
      return (mag >= 64) ? 64'd0 : v >> mag;
    end
    return (cnt >= 64) ? 64'd0 : v << cnt;
  endfunction

  function automatic logic [63:0] floor_quotient(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q, r;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (a[63] == b[63]) return q;
    if (r != 0) q = q + 1;
    return -q;
  endfunction

  function automatic alu_out_t alu_predict(logic [3:0] op, logic [63:0] a,
                                           logic [63:0] b);
    alu_out_t o;
    o.res = '0;
    o.dz = 1'b0;
    case (op)
      ifdsa_pkg::OP_ADD: o.res = a + b;
      ifdsa_pkg::OP_SUB: o.res = a - b;
      ifdsa_pkg::OP_MUL: o.res = a * b;
      ifdsa_pkg::OP_FDIV: begin
        if (b == 0) o.dz = 1'b1;
        else if (b == '1) o.res = -a;
        else o.res = floor_quotient(a, b);
      end
      ifdsa_pkg::OP_FMOD: begin
        if (b == 0) o.dz = 1'b1;
        else if (b == '1) o.res = '0;
        else o.res = a - floor_quotient(a, b) * b;
      end
      ifdsa_pkg::OP_NEG: o.res = -a;
      ifdsa_pkg::OP_AND: o.res = a & b;
      ifdsa_pkg::OP_OR:  o.res = a | b;
      ifdsa_pkg::OP_XOR: o.res = a ^ b;
      ifdsa_pkg::OP_NOT: o.res = ~a;
      ifdsa_pkg::OP_SHL: o.res = shift_by(a, b);
      ifdsa_pkg::OP_SHR: o.res = shift_by(a, -b);
      ifdsa_pkg::OP_EQ:  o.res = {63'd0, (a == b)};
      ifdsa_pkg::OP_LT:  o.res = {63'd0, ($signed(a) < $signed(b))};
      ifdsa_pkg::OP_LE:  o.res = {63'd0, ($signed(a) <= $signed(b))};
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = 64'($urandom_range(0, 4));
      1: v = -64'($urandom_range(1, 4));
      2: v = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 2));
      3: v = 64'h7fff_ffff_ffff_ffff - 64'($urandom_range(0, 2));
      4: v = $signed({{32{$urandom_range(0, 1) == 1}}, $urandom});
      5: v = $signed({{48{v[15]}}, v[15:0]});
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_item(logic [3:0] op, logic [63:0] a, logic [63:0] b);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    lhs <= a;
    rhs <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(alu_predict(op, a, b));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // receiver: randomize ready each cycle unless in reset or held off
  always @(posedge clk) begin
    if (rst || hold_receiver) out_ready <= 1'b0;
    else out_ready <= !(recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct);
  end

  // check each transfer against the oldest prediction
  always @(posedge clk) begin
    alu_out_t exp_o;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual %h dz %b", $time, result, divide_by_zero);
        errors++;
      end else begin
        exp_o = pending_results.pop_front();
        if (result !== exp_o.res) begin
          $display("%0t result mismatch: expected %h actual %h", $time, exp_o.res, result);
          errors++;
        end
        if (divide_by_zero !== exp_o.dz) begin
          $display("%0t divide_by_zero mismatch: expected %b actual %b", $time,
                   exp_o.dz, divide_by_zero);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    logic [63:0] mn, mx;
    mn = 64'h8000_0000_0000_0000;
    mx = 64'h7fff_ffff_ffff_ffff;
    send_item(ifdsa_pkg::OP_ADD, mx, 64'd1);
    send_item(ifdsa_pkg::OP_SUB, mn, 64'd1);
    send_item(ifdsa_pkg::OP_MUL, mn, '1);
    send_item(ifdsa_pkg::OP_FDIV, 64'd7, 64'd0);
    send_item(ifdsa_pkg::OP_FMOD, mn, 64'd0);
    send_item(ifdsa_pkg::OP_FDIV, mn, '1);
    send_item(ifdsa_pkg::OP_FMOD, mn, '1);
    send_item(ifdsa_pkg::OP_FDIV, -64'sd7, 64'd2);
    send_item(ifdsa_pkg::OP_FMOD, -64'sd7, 64'd2);
    send_item(ifdsa_pkg::OP_FMOD, 64'd7, -64'sd2);
    send_item(ifdsa_pkg::OP_FDIV, mn, mx);
    send_item(ifdsa_pkg::OP_NEG, mn, mx);
    send_item(ifdsa_pkg::OP_AND, mx, mn);
    send_item(ifdsa_pkg::OP_OR, mx, mn);
    send_item(ifdsa_pkg::OP_XOR, '1, mx);
    send_item(ifdsa_pkg::OP_NOT, 64'd0, '1);
    send_item(ifdsa_pkg::OP_SHL, '1, 64'd63);
    send_item(ifdsa_pkg::OP_SHL, '1, 64'd64);
    send_item(ifdsa_pkg::OP_SHL, '1, -64'sd63);
    send_item(ifdsa_pkg::OP_SHR, '1, -64'sd64);
    send_item(ifdsa_pkg::OP_SHR, '1, mn);
    send_item(ifdsa_pkg::OP_SHR, mn, 64'd63);
    send_item(ifdsa_pkg::OP_EQ, mn, mn);
    send_item(ifdsa_pkg::OP_LT, mn, mx);
    send_item(ifdsa_pkg::OP_LE, mx, mx);
    send_item(4'd15, mx, mx);
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    logic [3:0] op;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      op = 4'($urandom_range(0, 15));
      send_item(op, rand64(),
                (op >= ifdsa_pkg::OP_SHL && op <= ifdsa_pkg::OP_SHR && $urandom_range(0, 1))
                ? 64'($signed(8'($urandom))) : rand64());
    end
    wait_drained();
  endtask

  // hold the output off long enough that the pipeline fills and stalls its input
  task automatic test_backpressure();
    int held;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_receiver = 1'b1;
    fork
      begin
        for (held = 0; held < 300; held++) @(posedge clk);
        hold_receiver = 1'b0;
      end
      repeat (150) send_item(4'($urandom_range(0, 14)), rand64(), rand64());
    join
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random(400, 0, 0);
    test_random(300, 78, 0);
    test_random(300, 0, 78);
    test_random(300, 9, 9);
    test_backpressure();
    test_random(100, 0, 0);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/ifdsa_pkg.sv
hw/rtl/ifdsa_div_cell.sv
hw/rtl/int64_floor_div_shift_alu.sv
tb/int64_floor_div_shift_alu_test.sv
